### rtl/i2c_master_bit_sequencer_defines.svh
// Assertion macros shared by the RTL.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define I2CM_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/i2cm_seq_pkg.sv
package i2cm_seq_pkg;

	// Bits shifted per data byte
	localparam int unsigned BITS_PER_BYTE = 8;

	// Operation codes carried by an input word
	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_STOP  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_ACK   = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// Running command (state vector)
	localparam logic [2:0] CMD_IDLE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_ACK   = 3'd4;
	localparam logic [2:0] CMD_READ  = 3'd5;

	// Step phases within a command
	localparam logic [2:0] PH_0 = 3'd0;
	localparam logic [2:0] PH_1 = 3'd1;
	localparam logic [2:0] PH_2 = 3'd2;
	localparam logic [2:0] PH_3 = 3'd3;
	localparam logic [2:0] PH_4 = 3'd4;

	// Configuration register indexes
	localparam logic REG_DELAY_TICKS = 1'b0;
	localparam logic REG_ACK_TIMEOUT = 1'b1;

	// Register reset values
	localparam logic [7:0] DELAY_TICKS_RST = 8'd5;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	// Most significant bit of a byte
	localparam logic [7:0] BYTE_MSB = 8'h80;

endpackage

### rtl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer. Every input word is one timebase tick; tuser carries a
// command flag and operation (start, stop, write byte, wait for acknowledge, read
// byte with ACK/NACK), and each tick yields exactly one output word with the SCL,
// SDA and SDA-drive levels, busy, a one-tick done pulse, the last read byte and an
// ack-missing flag. A command is taken only on a tick that arrives while idle.
// Throughput is one tick per clock while the output is not stalled; a tick passes an
// input register and then a result register before its word is offered on the output.
// Line holds last delay_ticks ticks; the acknowledge wait polls SDA with SCL high and
// sends a STOP after ack_timeout failed polls. Configuration must be written while
// idle.
`include "i2c_master_bit_sequencer_defines.svh"

module i2c_master_bit_sequencer
	import i2cm_seq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// Tick input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] write_byte, [8] send_ack, [9] sda_in, rest 0
	input  logic [3:0]  s_axis_tuser,  // [0] cmd_valid, [3:1] operation
	// Result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [0] scl_level, [1] sda_level, [2] sda_drive,
	                                   // [3] busy_res, [4] done_res, [12:5] read_byte,
	                                   // [13] ack_missing, rest 0
);

	// Configuration
	logic [7:0] delay_ticks_q;
	logic [7:0] ack_timeout_q;

	// Input stage
	logic       valid_s1;
	logic       cmd_valid_s1;
	logic [2:0] operation_s1;
	logic [7:0] write_byte_s1;
	logic       send_ack_s1;
	logic       sda_in_s1;

	// Sequencer state
	logic [2:0] cmd_q;
	logic [2:0] phase_q;
	logic [7:0] dly_q;
	logic [3:0] bit_q;
	logic [7:0] shift_q;
	logic [7:0] poll_q;
	logic       ackc_q;
	logic       scl_q;
	logic       sda_q;
	logic       drv_q;
	logic       err_q;
	logic [7:0] rd_q;

	// Next state
	logic [2:0] n_cmd;
	logic [2:0] n_phase;
	logic [7:0] n_dly;
	logic [3:0] n_bit;
	logic [7:0] n_shift;
	logic [7:0] n_poll;
	logic       n_ackc;
	logic       n_scl;
	logic       n_sda;
	logic       n_drv;
	logic       n_err;
	logic [7:0] n_rd;
	logic       n_done;

	// Effective values for the action of this tick
	logic       act;
	logic [2:0] e_cmd;
	logic [2:0] e_phase;
	logic [3:0] e_bit;
	logic [7:0] e_shift;
	logic [7:0] e_poll;
	logic       e_ackc;
	logic [7:0] hold_full;
	logic [3:0] bit_inc;
	logic [7:0] poll_inc;
	logic [7:0] shift_smp;

	// Output register
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        advance;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= DELAY_TICKS_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELAY_TICKS: delay_ticks_q <= cfg_data;
				REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_valid_s1  <= s_axis_tuser[0];
			operation_s1  <= s_axis_tuser[3:1];
			write_byte_s1 <= s_axis_tdata[7:0];
			send_ack_s1   <= s_axis_tdata[8];
			sda_in_s1     <= s_axis_tdata[9];
		end
	end

	// Command launch: pick the values the first action sees
	always_comb begin
		act     = 1'b0;
		e_cmd   = cmd_q;
		e_phase = phase_q;
		e_bit   = bit_q;
		e_shift = shift_q;
		e_poll  = poll_q;
		e_ackc  = ackc_q;
		if (cmd_q == CMD_IDLE) begin
			if (cmd_valid_s1 && operation_s1 <= OP_READ) begin
				act     = 1'b1;
				e_cmd   = operation_s1 + 3'd1;
				e_phase = PH_0;
				e_bit   = 4'd0;
				e_poll  = 8'd0;
				e_shift = (operation_s1 == OP_WRITE) ? write_byte_s1 : 8'd0;
				e_ackc  = send_ack_s1;
			end
		end else if (dly_q == 8'd0) begin
			act = 1'b1;
		end
	end

	assign hold_full = (delay_ticks_q == 8'd0) ? 8'd0 : delay_ticks_q - 8'd1;
	assign bit_inc   = e_bit + 4'd1;
	assign poll_inc  = (e_poll < 8'd255) ? e_poll + 8'd1 : e_poll;
	assign shift_smp = {e_shift[6:0], sda_in_s1};

	// One step of the line sequence
	always_comb begin
		n_cmd   = e_cmd;
		n_phase = e_phase;
		n_dly   = dly_q;
		n_bit   = e_bit;
		n_shift = e_shift;
		n_poll  = e_poll;
		n_ackc  = e_ackc;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_drv   = drv_q;
		n_err   = err_q;
		n_rd    = rd_q;
		n_done  = 1'b0;
		if (cmd_q == CMD_IDLE && act && e_cmd == CMD_ACK) begin
			n_err = 1'b0;
		end
		if (!act) begin
			if (cmd_q != CMD_IDLE) begin
				n_dly = dly_q - 8'd1;
			end
		end else begin
			unique case (e_cmd)
				CMD_START: begin
					unique case (e_phase)
						PH_0: begin
							n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b1;
							n_dly = hold_full; n_phase = PH_1;
						end
						PH_1: begin
							n_sda = 1'b0; n_dly = hold_full; n_phase = PH_2;
						end
						default: begin
							n_scl = 1'b0;
							n_cmd = CMD_IDLE; n_phase = PH_0; n_dly = 8'd0; n_done = 1'b1;
						end
					endcase
				end
				CMD_STOP: begin
					unique case (e_phase)
						PH_0: begin
							n_scl = 1'b0; n_sda = 1'b0; n_drv = 1'b1;
							n_dly = 8'd0; n_phase = PH_1;
						end
						PH_1: begin
							n_scl = 1'b1; n_dly = hold_full; n_phase = PH_2;
						end
						PH_2: begin
							n_sda = 1'b1; n_dly = hold_full; n_phase = PH_3;
						end
						default: begin
							n_cmd = CMD_IDLE; n_phase = PH_0; n_dly = 8'd0; n_done = 1'b1;
						end
					endcase
				end
				CMD_WRITE: begin
					unique case (e_phase)
						PH_0: begin
							n_scl   = 1'b0; n_drv = 1'b1;
							n_sda   = |(e_shift & BYTE_MSB);
							n_shift = {e_shift[6:0], 1'b0};
							n_dly   = hold_full; n_phase = PH_1;
						end
						PH_1: begin
							n_scl = 1'b1; n_dly = hold_full; n_phase = PH_2;
						end
						PH_2: begin
							n_scl   = 1'b0; n_dly = hold_full;
							n_bit   = bit_inc;
							n_phase = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_3 : PH_0;
						end
						default: begin
							n_cmd = CMD_IDLE; n_phase = PH_0; n_dly = 8'd0; n_done = 1'b1;
						end
					endcase
				end
				CMD_ACK: begin
					unique case (e_phase)
						PH_0: begin
							n_drv = 1'b0; n_dly = hold_full; n_phase = PH_1;
						end
						PH_1: begin
							n_scl = 1'b1; n_dly = hold_full; n_phase = PH_2;
						end
						default: begin
							if (!sda_in_s1) begin
								n_scl = 1'b0;
								n_cmd = CMD_IDLE; n_phase = PH_0; n_dly = 8'd0; n_done = 1'b1;
							end else begin
								n_poll = poll_inc;
								if (poll_inc >= ack_timeout_q) begin
									// timeout: flag it and run the first STOP step now
									n_err   = 1'b1;
									n_cmd   = CMD_STOP;
									n_scl   = 1'b0; n_sda = 1'b0; n_drv = 1'b1;
									n_dly   = 8'd0; n_phase = PH_1;
								end else begin
									n_dly = 8'd0;
								end
							end
						end
					endcase
				end
				CMD_READ: begin
					unique case (e_phase)
						PH_0: begin
							if (e_bit != 4'd0) begin
								n_shift = shift_smp;
							end
							n_scl = 1'b0; n_drv = 1'b0; n_dly = hold_full; n_phase = PH_1;
						end
						PH_1: begin
							n_scl   = 1'b1; n_dly = hold_full;
							n_bit   = bit_inc;
							n_phase = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_2 : PH_0;
						end
						PH_2: begin
							n_shift = shift_smp;
							n_rd    = shift_smp;
							n_scl   = 1'b0; n_drv = 1'b1; n_sda = !e_ackc;
							n_dly   = hold_full; n_phase = PH_3;
						end
						PH_3: begin
							n_scl = 1'b1; n_dly = hold_full; n_phase = PH_4;
						end
						default: begin
							n_scl = 1'b0;
							n_cmd = CMD_IDLE; n_phase = PH_0; n_dly = 8'd0; n_done = 1'b1;
						end
					endcase
				end
				default: begin
					n_cmd = CMD_IDLE; n_phase = PH_0; n_dly = 8'd0; n_done = 1'b1;
				end
			endcase
		end
	end

	// State update, one tick per stage-one word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_IDLE;
			phase_q <= PH_0;
			dly_q   <= 8'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			poll_q  <= 8'd0;
			ackc_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			drv_q   <= 1'b1;
			err_q   <= 1'b0;
			rd_q    <= 8'd0;
		end else if (valid_s1 && advance) begin
			cmd_q   <= n_cmd;
			phase_q <= n_phase;
			dly_q   <= n_dly;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			poll_q  <= n_poll;
			ackc_q  <= n_ackc;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			drv_q   <= n_drv;
			err_q   <= n_err;
			rd_q    <= n_rd;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data_q <= {2'b00, n_err, n_rd, n_done, (n_cmd != CMD_IDLE),
				n_drv, n_sda, n_scl};
		end
	end

	// Checks
	`I2CM_ASSERT(a_done_not_busy, out_valid_q && out_data_q[4], !out_data_q[3],
		"done word still reports busy")
	`I2CM_ASSERT(a_bit_range, 1'b1, bit_q <= 4'(BITS_PER_BYTE),
		"bit counter beyond byte length")
	`I2CM_ASSERT(a_err_stop, $rose(err_q), cmd_q == CMD_STOP,
		"ack error raised without stop sequence")
	`I2CM_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance,
		valid_s1 && $stable(cmd_q) && $stable(dly_q),
		"stalled tick changed sequencer state")

endmodule
